// File: hdl/som_bmu_pkg.sv
// Shared types, codes and constants of the map search and update block.
// Used by som_bmu_search_and_update_unit; depends on nothing.
package som_bmu_pkg;

	localparam int NEURONS_DEF     = 64;
	localparam int DIMS_DEF        = 8;
	localparam int GAUSS_DEPTH_DEF = 64;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NEURONS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE    = 2'd1;

	localparam logic [6:0] NEURONS_IN_USE_RST = 7'd64;
	localparam logic [3:0] DIMS_IN_USE_RST    = 4'd8;

	// The dimension count register never counts above this.
	localparam int DIMS_HARD_CAP = 15;

	localparam logic RK_BMU  = 1'b0;
	localparam logic RK_READ = 1'b1;

	typedef enum logic [1:0] {
		ACT_WR_WEIGHT = 2'd0,
		ACT_WR_GRID   = 2'd1,
		ACT_SAMPLE    = 2'd2,
		ACT_RD_WEIGHT = 2'd3
	} action_t;

	// exp(-r/2) in Q0.16 from a Taylor series in Q32, rounded and saturated.
	// The argument is r in Q31, already scaled by the table depth.
	function automatic logic [15:0] gauss_entry(input logic [63:0] x);
		logic [63:0] t;
		longint      s;
		logic [63:0] r;
		t = 64'd1 << 32;
		s = longint'(t);
		t = ((t * x) >> 32) / 1;  s = s - longint'(t);
		t = ((t * x) >> 32) / 2;  s = s + longint'(t);
		t = ((t * x) >> 32) / 3;  s = s - longint'(t);
		t = ((t * x) >> 32) / 4;  s = s + longint'(t);
		t = ((t * x) >> 32) / 5;  s = s - longint'(t);
		t = ((t * x) >> 32) / 6;  s = s + longint'(t);
		t = ((t * x) >> 32) / 7;  s = s - longint'(t);
		t = ((t * x) >> 32) / 8;  s = s + longint'(t);
		t = ((t * x) >> 32) / 9;  s = s - longint'(t);
		t = ((t * x) >> 32) / 10; s = s + longint'(t);
		t = ((t * x) >> 32) / 11; s = s - longint'(t);
		t = ((t * x) >> 32) / 12; s = s + longint'(t);
		if (s < 0) begin
			s = 0;
		end
		r = (64'(s) + 64'd32768) >> 16;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

endpackage

// File: hdl/som_bmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module som_bmu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/som_bmu_cell.sv
// One cell of the sample ring: holds one sample component and rotates it
// toward cell zero. Depends on nothing.
module som_bmu_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               load,
	input  logic               shift,
	input  logic signed [15:0] wdata,
	input  logic signed [15:0] next_in,
	input  logic signed [15:0] head_in,
	input  logic [3:0]         dims,
	output logic signed [15:0] q
);
	logic signed [15:0] elem_q;

	// The ring closes after the last component in use, so after one full
	// vector's worth of shifts every cell holds its own component again.
	// Cells past the components in use keep their contents.
	always_ff @(posedge clk) begin
		if (load) begin
			elem_q <= wdata;
		end else if (shift && IDX < int'(dims)) begin
			elem_q <= (IDX + 1 < int'(dims)) ? next_in : head_in;
		end
	end

	assign q = elem_q;

endmodule

// File: hdl/som_bmu_div.sv
// Restoring long divider, one quotient bit per cycle, for the gain index.
// Depends on nothing.
module som_bmu_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q, quot_q;
	logic [DEN_W:0]   rem_q, rem_sh;
	logic [DEN_W-1:0] den_q;
	logic             ge;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (32'(cnt_q) == NUM_W - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: hdl/som_bmu_search_and_update_unit.sv
// Kohonen map training step: takes weight and grid writes and weight reads. A last
// sample element starts the search, which streams one weight a cycle through a ring
// of sample cells over nu neurons of du components each. The update then visits each
// neuron through the grid read, grid wait and test states; a neuron inside the
// neighborhood adds a bit-serial division, a step to form its gain and a
// read-modify-write of its weights on the single weight memory port pair.
// One item is worked at a time. Depends on som_bmu_pkg, som_bmu_ram,
// som_bmu_cell and som_bmu_div.
module som_bmu_search_and_update_unit #(
	parameter int NEURONS           = som_bmu_pkg::NEURONS_DEF,
	parameter int DIMS              = som_bmu_pkg::DIMS_DEF,
	parameter int GAUSS_TABLE_DEPTH = som_bmu_pkg::GAUSS_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [som_bmu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [som_bmu_pkg::CFG_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  som_bmu_pkg::action_t                 action,
	input  logic [5:0]                           neuron_index,
	input  logic [2:0]                           component_index,
	input  logic signed [15:0]                   value,
	input  logic [7:0]                           grid_x,
	input  logic [7:0]                           grid_y,
	input  logic [15:0]                          sigma,
	input  logic [15:0]                          learn_rate,
	input  logic                                 last_element,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 result_kind,
	output logic [5:0]                           bmu_index,
	output logic [35:0]                          bmu_distance,
	output logic signed [15:0]                   read_value
);
	import som_bmu_pkg::*;

	localparam int NW    = $clog2(NEURONS);
	localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int NCW   = $clog2(NEURONS + 1);
	localparam int IW    = $clog2(GAUSS_TABLE_DEPTH);
	localparam int NUM_W = 33 + $clog2(GAUSS_TABLE_DEPTH + 1);
	localparam int DCAP  = (DIMS < DIMS_HARD_CAP) ? DIMS : DIMS_HARD_CAP;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SEARCH, S_SDRAIN, S_BMU_RD, S_BMU_WAIT, S_GRID_RD,
		S_GRID_WAIT, S_TEST, S_DIV, S_FACTOR, S_UPD, S_UDRAIN, S_REPORT
	} state_t;

	state_t state_q;

	logic [6:0]  nu_q;
	logic [3:0]  du_q;
	logic [NCW-1:0] nu_eff;
	logic [3:0]  du_eff;

	logic in_acc, issue, d_last, n_last, wok, nok;
	logic [NW-1:0] ni_a;
	logic [DW-1:0] ci_a;
	logic [NW-1:0] n_q, best_q;
	logic [DW-1:0] d_q;

	logic out_valid_q, result_kind_q, rd_ok_q;
	logic [5:0]  bmu_index_q;
	logic [35:0] bmu_distance_q;
	logic [15:0] read_value_q;

	logic [15:0] sigma_q, rate_q, factor_q, bxy_q;
	logic [31:0] sig2_q;
	logic [16:0] dist_q, dx2, dy2;
	logic signed [8:0] dx, dy;
	logic [IW-1:0] idx_q;
	logic in_hood;

	// Weight and grid memories.
	logic            w_we;
	logic [NW+DW-1:0] w_waddr, w_raddr;
	logic [15:0]     w_wdata, w_rd;
	logic            g_we;
	logic [NW-1:0]   g_raddr;
	logic [15:0]     g_rd;

	// Search and update pipeline.
	logic             vld_s1, first_s1, last_s1, upd_s1;
	logic [NW-1:0]    n_s1;
	logic [NW+DW-1:0] addr_s1;
	logic signed [15:0] samp_s1;
	logic             vld_s2, first_s2, last_s2, upd_s2;
	logic [NW-1:0]    n_s2;
	logic [NW+DW-1:0] addr_s2;
	logic [33:0]      sq_s2;
	logic signed [33:0] prod_s2;
	logic [15:0]      w_s2;
	logic signed [16:0] diff;
	logic [35:0]      acc_q, best_d_q, acc_next;

	logic div_start, div_done;
	logic [NUM_W-1:0] div_quot;

	logic [15:0] gtab [GAUSS_TABLE_DEPTH];
	logic signed [15:0] ring [DIMS];

	// Effective counts after clamping out-of-range register values.
	always_comb begin
		if (nu_q == '0) begin
			nu_eff = NCW'(1);
		end else if (32'(nu_q) > NEURONS) begin
			nu_eff = NCW'(NEURONS);
		end else begin
			nu_eff = NCW'(nu_q);
		end
		if (du_q == '0) begin
			du_eff = 4'd1;
		end else if (32'(du_q) > DCAP) begin
			du_eff = 4'(DCAP);
		end else begin
			du_eff = du_q;
		end
	end

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign ni_a     = NW'(neuron_index);
	assign ci_a     = DW'(component_index);
	assign nok      = 32'(neuron_index) < NEURONS;
	assign wok      = nok && (32'(component_index) < DIMS);
	assign issue    = (state_q == S_SEARCH) || (state_q == S_UPD);
	assign d_last   = 32'(d_q) == 32'(du_eff) - 1;
	assign n_last   = 32'(n_q) == 32'(nu_eff) - 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_q <= NEURONS_IN_USE_RST;
			du_q <= DIMS_IN_USE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NEURONS_IN_USE: nu_q <= cfg_data;
				REG_DIMS_IN_USE:    du_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Gain table, filled at elaboration.
	for (genvar g = 0; g < GAUSS_TABLE_DEPTH; g++) begin : g_gtab
		localparam logic [63:0] GX = (64'(g) << 31) / 64'(GAUSS_TABLE_DEPTH);
		assign gtab[g] = gauss_entry(GX);
	end

	// Sample ring.
	for (genvar i = 0; i < DIMS; i++) begin : g_ring
		logic signed [15:0] nxt;
		if (i + 1 < DIMS) begin : g_mid
			assign nxt = ring[i + 1];
		end else begin : g_end
			assign nxt = ring[0];
		end
		som_bmu_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.load    (in_acc && action == ACT_SAMPLE && 32'(component_index) == i),
			.shift   (issue),
			.wdata   (value),
			.next_in (nxt),
			.head_in (ring[0]),
			.dims    (du_eff),
			.q       (ring[i])
		);
	end

	assign w_we    = (in_acc && action == ACT_WR_WEIGHT && wok) || (vld_s2 && upd_s2);
	assign w_waddr = (vld_s2 && upd_s2) ? addr_s2 : {ni_a, ci_a};
	assign w_wdata = (vld_s2 && upd_s2) ? w_s2 + 16'(prod_s2 >>> 16) : value;
	assign w_raddr = issue ? {n_q, d_q} : {ni_a, ci_a};

	som_bmu_ram #(.WIDTH(16), .DEPTH(2 ** (NW + DW))) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rd)
	);

	assign g_we    = in_acc && action == ACT_WR_GRID && nok;
	assign g_raddr = (state_q == S_BMU_RD) ? best_q : n_q;

	som_bmu_ram #(.WIDTH(16), .DEPTH(2 ** NW)) u_gram (
		.clk   (clk),
		.we    (g_we),
		.waddr (ni_a),
		.wdata ({grid_y, grid_x}),
		.raddr (g_raddr),
		.rdata (g_rd)
	);

	// Squared grid distance to the best match.
	assign dx      = $signed({1'b0, g_rd[7:0]}) - $signed({1'b0, bxy_q[7:0]});
	assign dy      = $signed({1'b0, g_rd[15:8]}) - $signed({1'b0, bxy_q[15:8]});
	assign dx2     = 17'(dx * dx);
	assign dy2     = 17'(dy * dy);
	assign in_hood = {dist_q, 16'b0} < 33'(sig2_q);
	assign div_start = (state_q == S_TEST) && in_hood;

	som_bmu_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NUM_W'({dist_q, 16'b0}) * NUM_W'(GAUSS_TABLE_DEPTH)),
		.den    (sig2_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Pipeline: s1 has the weight from memory, s2 has the square or the step.
	assign diff     = 17'(samp_s1) - 17'($signed(w_rd));
	assign acc_next = (first_s2 ? 36'd0 : acc_q) + 36'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (d_q == '0);
		last_s1  <= d_last;
		upd_s1   <= (state_q == S_UPD);
		n_s1     <= n_q;
		addr_s1  <= {n_q, d_q};
		samp_s1  <= ring[0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		upd_s2   <= upd_s1;
		n_s2     <= n_s1;
		addr_s2  <= addr_s1;
		sq_s2    <= 34'(diff * diff);
		prod_s2  <= 34'(diff * $signed({1'b0, factor_q}));
		w_s2     <= w_rd;
		if (vld_s2 && !upd_s2) begin
			acc_q <= acc_next;
			// Strict compare keeps the lowest index on ties.
			if (last_s2 && (n_s2 == '0 || acc_next < best_d_q)) begin
				best_q   <= n_s2;
				best_d_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			out_valid_q    <= 1'b0;
			result_kind_q  <= RK_BMU;
			bmu_index_q    <= '0;
			bmu_distance_q <= '0;
			read_value_q   <= '0;
			rd_ok_q        <= 1'b0;
			n_q            <= '0;
			d_q            <= '0;
			sigma_q        <= '0;
			rate_q         <= '0;
			sig2_q         <= '0;
			bxy_q          <= '0;
			dist_q         <= '0;
			idx_q          <= '0;
			factor_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			sig2_q <= sigma_q * sigma_q;
			unique case (state_q)
				S_IDLE: begin
					n_q <= '0;
					d_q <= '0;
					if (in_acc) begin
						unique case (action)
							ACT_RD_WEIGHT: begin
								rd_ok_q <= wok;
								state_q <= S_READ;
							end
							ACT_SAMPLE: begin
								sigma_q <= sigma;
								rate_q  <= learn_rate;
								if (last_element) begin
									state_q <= S_SEARCH;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					out_valid_q    <= 1'b1;
					result_kind_q  <= RK_READ;
					bmu_index_q    <= '0;
					bmu_distance_q <= '0;
					read_value_q   <= rd_ok_q ? w_rd : 16'd0;
					state_q        <= S_IDLE;
				end
				S_SEARCH: begin
					if (d_last) begin
						d_q <= '0;
						if (n_last) begin
							state_q <= S_SDRAIN;
						end else begin
							n_q <= n_q + 1'b1;
						end
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_SDRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= S_BMU_RD;
					end
				end
				S_BMU_RD: begin
					n_q     <= '0;
					state_q <= S_BMU_WAIT;
				end
				S_BMU_WAIT: begin
					bxy_q   <= g_rd;
					state_q <= S_GRID_RD;
				end
				S_GRID_RD: begin
					state_q <= S_GRID_WAIT;
				end
				S_GRID_WAIT: begin
					dist_q  <= dx2 + dy2;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (in_hood) begin
						state_q <= S_DIV;
					end else if (n_last) begin
						state_q <= S_REPORT;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_GRID_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q <= (div_quot >= NUM_W'(GAUSS_TABLE_DEPTH)) ?
							IW'(GAUSS_TABLE_DEPTH - 1) : div_quot[IW-1:0];
						state_q <= S_FACTOR;
					end
				end
				S_FACTOR: begin
					factor_q <= 16'((32'(rate_q) * 32'(gtab[idx_q])) >> 16);
					d_q      <= '0;
					state_q  <= S_UPD;
				end
				S_UPD: begin
					if (d_last) begin
						d_q     <= '0;
						state_q <= S_UDRAIN;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_UDRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						if (n_last) begin
							state_q <= S_REPORT;
						end else begin
							n_q     <= n_q + 1'b1;
							state_q <= S_GRID_RD;
						end
					end
				end
				S_REPORT: begin
					out_valid_q    <= 1'b1;
					result_kind_q  <= RK_BMU;
					bmu_index_q    <= 6'(best_q);
					bmu_distance_q <= best_d_q;
					read_value_q   <= '0;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign bmu_index    = bmu_index_q;
	assign bmu_distance = bmu_distance_q;
	assign read_value   = read_value_q;

	// A last sample element always starts the search on the next cycle.
	a_search_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action == ACT_SAMPLE && last_element |=> state_q == S_SEARCH)
		else $error("search did not start after last sample element");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	// Weight write-back never collides with a request being taken.
	a_wb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && upd_s2 |-> !in_ready && state_q != S_IDLE)
		else $error("weight write-back while requests are accepted");

	// A best-match report only comes out of the report state.
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q ##1 out_valid_q && result_kind_q == RK_BMU |->
		$past(state_q) == S_REPORT)
		else $error("best-match report without finished search");

endmodule
